// File: rtl/sti_pkg.sv
package sti_pkg;

  localparam int CoordW = 20;
  localparam int PtW    = 3 * CoordW;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int SplitW = 22;
  localparam int DotW   = 64;
  localparam int RegW   = 24;
  localparam int TaW    = DotW + RegW;
  localparam int HalfW  = DotW / 2;

  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic signed [DotW-1:0]   dot_t;
  typedef logic [RegW-1:0]          reg_t;

  typedef diff_t  vec_t   [3];
  typedef cross_t cvec_t  [3];
  typedef prod_t  pvec_t  [3];

  typedef enum logic {
    CFG_DET_EPS = 1'b0,
    CFG_T_EPS   = 1'b1
  } cfg_idx_e;

  localparam int NextA [3] = '{1, 2, 0};
  localparam int NextB [3] = '{2, 0, 1};

  localparam reg_t DetEpsRst = reg_t'(168);
  localparam reg_t TEpsRst   = reg_t'(168);

  function automatic diff_t coord(input logic [PtW-1:0] w, input int k);
    logic signed [CoordW-1:0] c;
    c = w[k*CoordW +: CoordW];
    return diff_t'(c);
  endfunction

endpackage

// File: rtl/sti_in_if.sv
interface sti_in_if;
  logic                      valid;
  logic                      ready;
  logic [sti_pkg::PtW-1:0]   seg_start;
  logic [sti_pkg::PtW-1:0]   seg_end;
  logic [sti_pkg::PtW-1:0]   vert_zero;
  logic [sti_pkg::PtW-1:0]   vert_one;
  logic [sti_pkg::PtW-1:0]   vert_two;

  modport source(output valid, seg_start, seg_end, vert_zero, vert_one, vert_two,
                 input ready);
  modport sink(input valid, seg_start, seg_end, vert_zero, vert_one, vert_two,
               output ready);
endinterface

// File: rtl/sti_out_if.sv
interface sti_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic parallel;

  modport source(output valid, hit, parallel, input ready);
  modport sink(input valid, hit, parallel, output ready);
endinterface

// File: rtl/sti_dot3.sv
module sti_dot3 (
  input  logic           clk_i,
  input  logic           en_i,
  input  sti_pkg::vec_t  a_i,
  input  sti_pkg::cvec_t b_i,
  output sti_pkg::dot_t  dot_o
);

  logic signed [sti_pkg::DiffW+sti_pkg::SplitW:0] lo_d [3];
  logic signed [sti_pkg::DiffW+sti_pkg::SplitW:0] lo_q [3];
  logic signed [sti_pkg::DiffW+sti_pkg::CrossW-sti_pkg::SplitW-1:0] hi_d [3];
  logic signed [sti_pkg::DiffW+sti_pkg::CrossW-sti_pkg::SplitW-1:0] hi_q [3];
  sti_pkg::dot_t dot_d, dot_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_d[k] = a_i[k] * $signed({1'b0, b_i[k][sti_pkg::SplitW-1:0]});
      hi_d[k] = a_i[k] * $signed(b_i[k][sti_pkg::CrossW-1:sti_pkg::SplitW]);
    end
  end

  always_comb begin
    dot_d = '0;
    for (int k = 0; k < 3; k++) begin
      dot_d = dot_d + (sti_pkg::dot_t'(hi_q[k]) <<< sti_pkg::SplitW)
                    + sti_pkg::dot_t'(lo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      dot_q <= dot_d;
    end
  end

  assign dot_o = dot_q;

endmodule

// File: rtl/segment_triangle_intersection.sv
// Segment / triangle crossing test, one pair per cycle while out_o is not stalled.
// in_i carries a segment (start, end) and a triangle (three vertices), each
// point three signed Q11.8 coordinates. out_o returns hit and parallel for
// each transfer, in order. cfg_we_i/cfg_idx_i/cfg_wdata_i write the
// determinant epsilon (index 0) and the t epsilon (index 1); write them only
// while no item is in flight.
// Throughput is one item per cycle while out_o is not stalled: a seven-stage
// pipeline, set by splitting each dot product and the t-epsilon scaling into
// registered partial products.
// The whole pipeline advances together; when out_o is stalled every stage
// holds and in_i.ready drops, so nothing is lost or repeated.
// Reset clears all stage valid bits and loads both epsilons with 168.
module segment_triangle_intersection (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  sti_pkg::cfg_idx_e    cfg_idx_i,
  input  sti_pkg::reg_t        cfg_wdata_i,
  sti_in_if.sink               in_i,
  sti_out_if.source            out_o
);

  sti_pkg::reg_t det_eps_q, t_eps_q;
  logic          en;
  logic [6:1]    vld_q;

  sti_pkg::vec_t  d_d, e1_d, e2_d, s_d;
  sti_pkg::vec_t  d1_q, e11_q, e21_q, s1_q;
  sti_pkg::pvec_t hp0_d, hp1_d, qp0_d, qp1_d;
  sti_pkg::pvec_t hp0_q, hp1_q, qp0_q, qp1_q;
  sti_pkg::vec_t  d2_q, e12_q, e22_q, s2_q;
  sti_pkg::cvec_t h_d, q_d, h_q, q_q;
  sti_pkg::vec_t  d3_q, e13_q, e23_q, s3_q;
  sti_pkg::dot_t  a_dot, u_dot, v_dot, t_dot;

  sti_pkg::dot_t  a_f, u_f, v_f, t_f;
  logic signed [sti_pkg::DotW:0] av_diff;
  logic           cond_d, cond_q, par_d, par_q;
  sti_pkg::dot_t  nt_q;
  logic [sti_pkg::HalfW+sti_pkg::RegW-1:0] tlo_d, thi_d, tlo_q, thi_q;
  logic [sti_pkg::TaW-1:0] ta, tt;

  logic out_valid_q, hit_q, out_par_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_eps_q <= sti_pkg::DetEpsRst;
      t_eps_q   <= sti_pkg::TEpsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sti_pkg::CFG_DET_EPS: det_eps_q <= cfg_wdata_i;
        sti_pkg::CFG_T_EPS:   t_eps_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[5:1], in_i.valid};
      out_valid_q <= vld_q[6];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k]  = sti_pkg::coord(in_i.seg_end, k) - sti_pkg::coord(in_i.seg_start, k);
      e1_d[k] = sti_pkg::coord(in_i.vert_one, k) - sti_pkg::coord(in_i.vert_zero, k);
      e2_d[k] = sti_pkg::coord(in_i.vert_two, k) - sti_pkg::coord(in_i.vert_zero, k);
      s_d[k]  = sti_pkg::coord(in_i.seg_start, k) - sti_pkg::coord(in_i.vert_zero, k);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hp0_d[k] = d1_q[sti_pkg::NextA[k]] * e21_q[sti_pkg::NextB[k]];
      hp1_d[k] = d1_q[sti_pkg::NextB[k]] * e21_q[sti_pkg::NextA[k]];
      qp0_d[k] = s1_q[sti_pkg::NextA[k]] * e11_q[sti_pkg::NextB[k]];
      qp1_d[k] = s1_q[sti_pkg::NextB[k]] * e11_q[sti_pkg::NextA[k]];
      h_d[k]   = sti_pkg::cross_t'(hp0_q[k]) - sti_pkg::cross_t'(hp1_q[k]);
      q_d[k]   = sti_pkg::cross_t'(qp0_q[k]) - sti_pkg::cross_t'(qp1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q  <= d_d;
      e11_q <= e1_d;
      e21_q <= e2_d;
      s1_q  <= s_d;
      hp0_q <= hp0_d;
      hp1_q <= hp1_d;
      qp0_q <= qp0_d;
      qp1_q <= qp1_d;
      d2_q  <= d1_q;
      e12_q <= e11_q;
      e22_q <= e21_q;
      s2_q  <= s1_q;
      h_q   <= h_d;
      q_q   <= q_d;
      d3_q  <= d2_q;
      e13_q <= e12_q;
      e23_q <= e22_q;
      s3_q  <= s2_q;
    end
  end

  sti_dot3 u_dot_a (.clk_i, .en_i(en), .a_i(e13_q), .b_i(h_q), .dot_o(a_dot));
  sti_dot3 u_dot_u (.clk_i, .en_i(en), .a_i(s3_q),  .b_i(h_q), .dot_o(u_dot));
  sti_dot3 u_dot_v (.clk_i, .en_i(en), .a_i(d3_q),  .b_i(q_q), .dot_o(v_dot));
  sti_dot3 u_dot_t (.clk_i, .en_i(en), .a_i(e23_q), .b_i(q_q), .dot_o(t_dot));

  always_comb begin
    if (a_dot[sti_pkg::DotW-1]) begin
      a_f = -a_dot;
      u_f = -u_dot;
      v_f = -v_dot;
      t_f = -t_dot;
    end else begin
      a_f = a_dot;
      u_f = u_dot;
      v_f = v_dot;
      t_f = t_dot;
    end
    av_diff = {a_f[sti_pkg::DotW-1], a_f} - {u_f[sti_pkg::DotW-1], u_f};
    par_d   = (a_f == '0) ||
              ($unsigned(a_f) < {{(sti_pkg::DotW-sti_pkg::RegW){1'b0}}, det_eps_q});
    cond_d  = !u_f[sti_pkg::DotW-1] && (u_f <= a_f) &&
              !v_f[sti_pkg::DotW-1] && ($signed({v_f[sti_pkg::DotW-1], v_f}) <= av_diff) &&
              !t_f[sti_pkg::DotW-1] && (t_f != '0) && (t_f <= a_f);
    tlo_d   = a_f[sti_pkg::HalfW-1:0] * t_eps_q;
    thi_d   = a_f[sti_pkg::DotW-1:sti_pkg::HalfW] * t_eps_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_q  <= par_d;
      cond_q <= cond_d;
      nt_q   <= t_f;
      tlo_q  <= tlo_d;
      thi_q  <= thi_d;
    end
  end

  assign ta = (sti_pkg::TaW'(thi_q) << sti_pkg::HalfW) + sti_pkg::TaW'(tlo_q);
  assign tt = {nt_q, {sti_pkg::RegW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q     <= !par_q && cond_q && (tt > ta);
      out_par_q <= par_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = hit_q;
  assign out_o.parallel = out_par_q;

  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && out_par_q))
    else $error("hit and parallel both set");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[6]))
    else $error("output valid without a stage-six item");

endmodule
